// File: sv/srma_pkg.sv
// ----------------------------------------------------------------------------
// srma_pkg: shared types and constants for the slab moment accumulator
// Holds the sequencer states, op codes, store entry layout and the fixed
// widths of the reciprocal unit.
// ----------------------------------------------------------------------------
package srma_pkg;

  localparam int unsigned ACC_W      = 48;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned MAG_W      = 18;
  localparam int unsigned RECIP_BITS = 33;   // 2^32 + |c|/2 needs 33 bits
  localparam int unsigned HGT_W      = 19;
  localparam int unsigned LVL_W      = 12;   // signed level index
  localparam int unsigned PROD_W     = 27;   // |height| * n

  localparam logic signed [HGT_W-1:0] ONE_Q16 = 19'sd65536;

  typedef enum logic [1:0] {
    OP_SEGMENT = 2'd0,
    OP_READ    = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_WIPE,
    ST_IDLE,
    ST_LVL_B,
    ST_LVL_A,
    ST_BOUNDS,
    ST_RECIP,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_RD_LVL,
    ST_RD_WAIT,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [ACC_W-1:0]        ju;
    logic [CNT_W-1:0]        hu;
    logic [ACC_W-1:0]        ku;
    logic [ACC_W-1:0]        jd;
    logic signed [CNT_W-1:0] hd;
    logic [ACC_W-1:0]        kd;
  } entry_t;

endpackage

// File: sv/srma_recip.sv
// ----------------------------------------------------------------------------
// srma_recip: rounded Q16 reciprocal of a cosine magnitude
// Restoring divider, one quotient bit per cycle, computing
// (2^32 + mag/2) / mag. Pulses done_o when the quotient is ready.
// ----------------------------------------------------------------------------
module srma_recip (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [srma_pkg::MAG_W-1:0]          mag_i,
  output logic                                done_o,
  output logic [srma_pkg::RECIP_BITS-1:0]     quot_o
);

  localparam int unsigned CW = $clog2(srma_pkg::RECIP_BITS);

  logic [srma_pkg::RECIP_BITS-1:0] num_q;
  logic [srma_pkg::MAG_W-1:0]      rem_q;
  logic [srma_pkg::MAG_W-1:0]      div_q;
  logic [CW-1:0]                   cnt_q;
  logic                            run_q;
  logic                            done_q;

  logic [srma_pkg::MAG_W:0]        rem_sh;
  logic [srma_pkg::MAG_W:0]        rem_sub;
  logic                            fits;

  assign rem_sh  = {rem_q, num_q[srma_pkg::RECIP_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign fits    = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(srma_pkg::RECIP_BITS - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift the numerator out at the top, quotient bits in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {1'b1, 32'd0} + srma_pkg::RECIP_BITS'(mag_i >> 1);
      rem_q <= '0;
      div_q <= mag_i;
    end else if (run_q) begin
      num_q <= {num_q[srma_pkg::RECIP_BITS-2:0], fits};
      rem_q <= fits ? rem_sub[srma_pkg::MAG_W-1:0] : rem_sh[srma_pkg::MAG_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

// File: sv/slab_radiation_moment_accumulator.sv
// ----------------------------------------------------------------------------
// slab_radiation_moment_accumulator: per-level j, h, k sums of photon segments
// A segment item finds its crossed levels in ST_LVL_B, ST_LVL_A and ST_BOUNDS,
// waits in ST_RECIP for the bit-serial reciprocal unit, then does one
// read-modify-write of the level store per crossed level (ST_RMW_RD, then
// ST_RMW_WR), then reports in ST_FINISH; when nothing is crossed it goes from
// ST_BOUNDS straight to ST_FINISH. A read item reads the store in ST_RD_LVL
// and ST_RD_WAIT, and goes straight to ST_FINISH when the level lies beyond the
// store; a clear item sweeps the store one level a cycle. After reset busy
// stays high for a clearing pass over the whole store. Each result is shown
// for a single cycle with result_valid_o high and cannot be held off; the
// result ports keep their value until the next item is accepted.
// ----------------------------------------------------------------------------
module slab_radiation_moment_accumulator #(
  parameter int unsigned MAX_LEVELS = 255
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i,
  input  logic [1:0]          op_i,
  input  logic signed [18:0]  height_before_i,
  input  logic signed [18:0]  height_after_i,
  input  logic signed [17:0]  direction_cosine_i,
  input  logic [7:0]          read_level_i,
  output logic                result_valid_o,
  output logic [47:0]         mean_intensity_up_o,
  output logic [31:0]         flux_up_o,
  output logic [47:0]         pressure_up_o,
  output logic [47:0]         mean_intensity_down_o,
  output logic signed [31:0]  flux_down_o,
  output logic [47:0]         pressure_down_o,
  output logic [8:0]          levels_touched_o
);

  localparam int unsigned DEPTH = MAX_LEVELS + 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [12:0] MaxLv = 13'(MAX_LEVELS);
  localparam logic [AW-1:0] LastAddr = AW'(MAX_LEVELS);
  localparam int unsigned LW = srma_pkg::LVL_W;
  localparam logic signed [LW-1:0] LvOne = LW'(1);

  function automatic logic signed [LW-1:0] lvl_of(input logic [srma_pkg::PROD_W-1:0] p,
                                                   input logic neg);
    logic signed [LW-1:0] m;
    m = $signed({1'b0, p[srma_pkg::PROD_W-1:16]});
    return neg ? -m : m;
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  srma_pkg::state_e state_q, state_d;

  // store
  srma_pkg::entry_t mem [DEPTH];
  srma_pkg::entry_t rdata_q;
  srma_pkg::entry_t upd;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  srma_pkg::entry_t mem_wdata;

  // control and item registers
  logic [7:0]                         lc_q;
  logic [AW-1:0]                      clr_q;
  logic [1:0]                         op_q;
  logic signed [18:0]                 zb_q, za_q;
  logic signed [17:0]                 c_q;
  logic [7:0]                         rl_q;
  logic [srma_pkg::PROD_W-1:0]        prod_q;
  logic signed [LW-1:0]               lb_q;
  logic [7:0]                         idx_q, hi_q;
  logic [srma_pkg::RECIP_BITS-1:0]    recip_q;

  // result registers
  logic [47:0]        ju_q, ku_q, jd_q, kd_q;
  logic [31:0]        hu_q;
  logic signed [31:0] hd_q;
  logic [8:0]         touched_q;

  // combinational
  logic [7:0]                      n_w;
  logic [18:0]                     mul_a;
  logic [srma_pkg::MAG_W-1:0]      mag_w;
  logic                            up_w;
  logic signed [LW-1:0]            la_w, lo_w, hi_w, span_w, n_s;
  logic                            seg_skip;
  logic                            clr_last;
  logic                            rd_ok;
  logic                            accept;
  logic                            div_start, div_done;
  logic [srma_pkg::RECIP_BITS-1:0] div_quot;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign n_w         = (13'(lc_q) < MaxLv) ? lc_q : MaxLv[7:0];
  assign n_s         = $signed(LW'(n_w));
  assign clr_last    = clr_q == LastAddr;
  assign rd_ok       = 13'(read_level_i) <= MaxLv;
  assign mag_w       = c_q[17] ? 18'(-c_q) : 18'(c_q);
  assign up_w        = c_q > 0;

  always_comb begin
    if (state_q == srma_pkg::ST_LVL_B) begin
      mul_a = zb_q[18] ? 19'(-zb_q) : 19'(zb_q);
    end else begin
      mul_a = za_q[18] ? 19'(-za_q) : 19'(za_q);
    end
  end

  // crossed level range of the segment
  always_comb begin
    la_w = lvl_of(prod_q, za_q[18]);
    if (up_w) begin
      lo_w = (zb_q <= 0) ? '0 : lb_q + LvOne;
      hi_w = (za_q >= srma_pkg::ONE_Q16) ? n_s : la_w;
    end else begin
      lo_w = (za_q <= 0) ? '0 : la_w + LvOne;
      hi_w = lb_q;
    end
    if (lo_w < 0) begin
      lo_w = '0;
    end
    if (hi_w > n_s) begin
      hi_w = n_s;
    end
    span_w   = hi_w - lo_w + LvOne;
    seg_skip = (zb_q > 0 && za_q > 0 && lb_q == la_w) || (c_q == 0) || (hi_w < lo_w);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srma_pkg::ST_WIPE: begin
        if (clr_last) state_d = srma_pkg::ST_IDLE;
      end
      srma_pkg::ST_IDLE: begin
        if (start) begin
          case (srma_pkg::op_e'(op_i))
            srma_pkg::OP_SEGMENT: state_d = srma_pkg::ST_LVL_B;
            srma_pkg::OP_READ:    state_d = rd_ok ? srma_pkg::ST_RD_LVL : srma_pkg::ST_FINISH;
            srma_pkg::OP_CLEAR:   state_d = srma_pkg::ST_CLEAR;
            default:              state_d = srma_pkg::ST_FINISH;
          endcase
        end
      end
      srma_pkg::ST_LVL_B:  state_d = srma_pkg::ST_LVL_A;
      srma_pkg::ST_LVL_A:  state_d = srma_pkg::ST_BOUNDS;
      srma_pkg::ST_BOUNDS: state_d = seg_skip ? srma_pkg::ST_FINISH : srma_pkg::ST_RECIP;
      srma_pkg::ST_RECIP: begin
        if (div_done) state_d = srma_pkg::ST_RMW_RD;
      end
      srma_pkg::ST_RMW_RD: state_d = srma_pkg::ST_RMW_WR;
      srma_pkg::ST_RMW_WR: state_d = (idx_q == hi_q) ? srma_pkg::ST_FINISH
                                                     : srma_pkg::ST_RMW_RD;
      srma_pkg::ST_RD_LVL:  state_d = srma_pkg::ST_RD_WAIT;
      srma_pkg::ST_RD_WAIT: state_d = srma_pkg::ST_FINISH;
      srma_pkg::ST_CLEAR: begin
        if (clr_last) state_d = srma_pkg::ST_FINISH;
      end
      srma_pkg::ST_FINISH: state_d = srma_pkg::ST_IDLE;
      default:             state_d = srma_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy           = state_q != srma_pkg::ST_IDLE;
    result_valid_o = state_q == srma_pkg::ST_FINISH;
    div_start      = (state_q == srma_pkg::ST_BOUNDS) && !seg_skip;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = AW'(idx_q);
    mem_raddr      = AW'(idx_q);
    mem_wdata      = upd;
    case (state_q)
      srma_pkg::ST_WIPE, srma_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      srma_pkg::ST_RMW_RD: mem_re = 1'b1;
      srma_pkg::ST_RMW_WR: mem_we = 1'b1;
      srma_pkg::ST_RD_LVL: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(rl_q);
      end
      default: ;
    endcase
  end

  // saturating update of one level
  always_comb begin
    upd = rdata_q;
    if (up_w) begin
      upd.ju = sat_add48(rdata_q.ju, 48'(recip_q));
      upd.ku = sat_add48(rdata_q.ku, 48'(mag_w));
      if (rdata_q.hu != '1) upd.hu = rdata_q.hu + 1'b1;
    end else begin
      upd.jd = sat_add48(rdata_q.jd, 48'(recip_q));
      upd.kd = sat_add48(rdata_q.kd, 48'(mag_w));
      if (rdata_q.hd != 32'sh8000_0000) upd.hd = rdata_q.hd - 32'sd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srma_pkg::ST_WIPE;
      lc_q    <= 8'd255;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) lc_q <= cfg_data_i;
      if (state_q == srma_pkg::ST_WIPE || state_q == srma_pkg::ST_CLEAR) begin
        clr_q <= clr_last ? '0 : clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      srma_pkg::ST_IDLE: begin
        if (accept) begin
          op_q      <= op_i;
          zb_q      <= height_before_i;
          za_q      <= height_after_i;
          c_q       <= direction_cosine_i;
          rl_q      <= read_level_i;
          ju_q      <= '0;
          hu_q      <= '0;
          ku_q      <= '0;
          jd_q      <= '0;
          hd_q      <= '0;
          kd_q      <= '0;
          touched_q <= '0;
        end
      end
      srma_pkg::ST_LVL_B: prod_q <= srma_pkg::PROD_W'(mul_a) * srma_pkg::PROD_W'(n_w);
      srma_pkg::ST_LVL_A: begin
        lb_q   <= lvl_of(prod_q, zb_q[18]);
        prod_q <= srma_pkg::PROD_W'(mul_a) * srma_pkg::PROD_W'(n_w);
      end
      srma_pkg::ST_BOUNDS: begin
        idx_q     <= lo_w[7:0];
        hi_q      <= hi_w[7:0];
        touched_q <= seg_skip ? '0 : span_w[8:0];
      end
      srma_pkg::ST_RECIP: begin
        if (div_done) recip_q <= div_quot;
      end
      srma_pkg::ST_RMW_WR: idx_q <= idx_q + 1'b1;
      srma_pkg::ST_RD_WAIT: begin
        ju_q <= rdata_q.ju;
        hu_q <= rdata_q.hu;
        ku_q <= rdata_q.ku;
        jd_q <= rdata_q.jd;
        hd_q <= rdata_q.hd;
        kd_q <= rdata_q.kd;
      end
      default: ;
    endcase
  end

  srma_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (mag_w),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign mean_intensity_up_o   = ju_q;
  assign flux_up_o             = hu_q;
  assign pressure_up_o         = ku_q;
  assign mean_intensity_down_o = jd_q;
  assign flux_down_o           = hd_q;
  assign pressure_down_o       = kd_q;
  assign levels_touched_o      = touched_q;

  // a segment item reports a level count and no sums
  a_seg_no_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && op_q == srma_pkg::OP_SEGMENT) |-> (hu_q == '0 && hd_q == '0))
    else $error("segment result carries sums");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr <= LastAddr))
    else $error("store write beyond last level");

  a_rmw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srma_pkg::ST_RMW_RD) |-> (idx_q <= hi_q && 13'(idx_q) <= MaxLv))
    else $error("level walk beyond upper bound");

endmodule

// File: bench/slab_moment_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_moment_checker: predicts and checks the per-level j, h, k sums
// Watches the command, configuration and result channels of the slab moment
// accumulator. It keeps its own copy of the level stores and the level count,
// works out the result of every accepted item and compares each strobed
// result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module slab_moment_checker #(
  parameter int unsigned MAX_LEVELS = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i,
  input  logic [1:0]         op_i,
  input  logic signed [18:0] height_before_i,
  input  logic signed [18:0] height_after_i,
  input  logic signed [17:0] direction_cosine_i,
  input  logic [7:0]         read_level_i,
  input  logic               result_valid_o,
  input  logic [47:0]        mean_intensity_up_o,
  input  logic [31:0]        flux_up_o,
  input  logic [47:0]        pressure_up_o,
  input  logic [47:0]        mean_intensity_down_o,
  input  logic signed [31:0] flux_down_o,
  input  logic [47:0]        pressure_down_o,
  input  logic [8:0]         levels_touched_o,
  output int                 fail_count,
  output int                 due_count
);

  localparam longint Q16_ONE = 65536;
  localparam longint unsigned SAT48 = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct {
    logic [47:0] ju;
    logic [31:0] hu;
    logic [47:0] ku;
    logic [47:0] jd;
    logic [31:0] hd;
    logic [47:0] kd;
    logic [8:0]  touched;
  } slab_result_t;

  logic [7:0]         level_count;
  logic [47:0]        ju_store [0:MAX_LEVELS];
  logic [31:0]        hu_store [0:MAX_LEVELS];
  logic [47:0]        ku_store [0:MAX_LEVELS];
  logic [47:0]        jd_store [0:MAX_LEVELS];
  logic signed [31:0] hd_store [0:MAX_LEVELS];
  logic [47:0]        kd_store [0:MAX_LEVELS];

  slab_result_t moments_due [$];
  int           mismatches = 0;

  function automatic void wipe_store();
    for (int i = 0; i <= MAX_LEVELS; i++) begin
      ju_store[i] = '0;
      hu_store[i] = '0;
      ku_store[i] = '0;
      jd_store[i] = '0;
      hd_store[i] = '0;
      kd_store[i] = '0;
    end
  endfunction

  function automatic logic [47:0] sat_add48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

  // Truncate toward zero on both sides of the floor
  function automatic longint slab_level(longint z, longint n);
    if (z < 0) return -(((-z) * n) / Q16_ONE);
    return (z * n) / Q16_ONE;
  endfunction

  function automatic logic [8:0] deposit(longint zb, longint za, longint c);
    longint n, lb, la, lo, hi, mag;
    longint unsigned recip;
    n  = (level_count < MAX_LEVELS) ? longint'(level_count) : longint'(MAX_LEVELS);
    lb = slab_level(zb, n);
    la = slab_level(za, n);
    if (zb > 0 && za > 0 && lb == la) return '0;
    if (c == 0) return '0;
    if (c > 0) begin
      lo = (zb <= 0) ? 0 : lb + 1;
      hi = (za >= Q16_ONE) ? n : la;
    end else begin
      lo = (za <= 0) ? 0 : la + 1;
      hi = lb;
    end
    if (lo < 0) lo = 0;
    if (hi > n) hi = n;
    if (hi < lo) return '0;
    mag   = (c < 0) ? -c : c;
    recip = ((64'd1 << 32) + longint'(mag / 2)) / mag;
    if (recip > SAT48) recip = SAT48;
    for (longint i = lo; i <= hi; i++) begin
      if (c > 0) begin
        ju_store[i] = sat_add48(ju_store[i], recip[47:0]);
        if (hu_store[i] != 32'hFFFF_FFFF) hu_store[i] = hu_store[i] + 1;
        ku_store[i] = sat_add48(ku_store[i], mag[47:0]);
      end else begin
        jd_store[i] = sat_add48(jd_store[i], recip[47:0]);
        if (hd_store[i] != 32'sh8000_0000) hd_store[i] = hd_store[i] - 1;
        kd_store[i] = sat_add48(kd_store[i], mag[47:0]);
      end
    end
    return 9'(hi - lo + 1);
  endfunction

  function automatic slab_result_t predict_moments(srma_pkg::op_e op,
                                                   logic signed [18:0] hb,
                                                   logic signed [18:0] ha,
                                                   logic signed [17:0] dc,
                                                   logic [7:0] lvl);
    slab_result_t m;
    m = '{default: '0};
    case (op)
      srma_pkg::OP_SEGMENT: m.touched = deposit(hb, ha, dc);
      srma_pkg::OP_READ: begin
        if (lvl <= MAX_LEVELS) begin
          m.ju = ju_store[lvl];
          m.hu = hu_store[lvl];
          m.ku = ku_store[lvl];
          m.jd = jd_store[lvl];
          m.hd = hd_store[lvl];
          m.kd = kd_store[lvl];
        end
      end
      srma_pkg::OP_CLEAR: wipe_store();
      default: ;
    endcase
    return m;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    slab_result_t want;
    if (!rst_ni) begin
      level_count = 8'd255;
      wipe_store();
      moments_due.delete();
      due_count  <= 0;
      fail_count <= mismatches;
    end else begin
      if (cfg_valid_i && cfg_ready_o) level_count = cfg_data_i;
      if (result_valid_o) begin
        if (moments_due.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, actual levels %0h",
                   $time, levels_touched_o);
          mismatches++;
        end else begin
          want = moments_due.pop_front();
          check_field("mean_intensity_up", want.ju, mean_intensity_up_o);
          check_field("flux_up", want.hu, flux_up_o);
          check_field("pressure_up", want.ku, pressure_up_o);
          check_field("mean_intensity_down", want.jd, mean_intensity_down_o);
          check_field("flux_down", want.hd, $unsigned(flux_down_o));
          check_field("pressure_down", want.kd, pressure_down_o);
          check_field("levels_touched", want.touched, levels_touched_o);
        end
      end
      if (start && !busy)
        moments_due.push_back(predict_moments(srma_pkg::op_e'(op_i), height_before_i,
                                              height_after_i, direction_cosine_i,
                                              read_level_i));
      due_count  <= moments_due.size();
      fail_count <= mismatches;
    end
  end

endmodule

// File: bench/slab_radiation_moment_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_radiation_moment_accumulator_tb: stimulus and verdict
// Drives photon segments, level reads, clears and unused ops into the slab
// moment accumulator in random bursts, under several level counts, and
// leaves prediction and comparison to the checker placed beside the block.
// ----------------------------------------------------------------------------
module slab_radiation_moment_accumulator_tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [7:0]         cfg_data_i = '0;
  logic [1:0]         op_i = '0;
  logic signed [18:0] height_before_i = '0;
  logic signed [18:0] height_after_i = '0;
  logic signed [17:0] direction_cosine_i = '0;
  logic [7:0]         read_level_i = '0;
  logic               result_valid_o;
  logic [47:0]        mean_intensity_up_o;
  logic [31:0]        flux_up_o;
  logic [47:0]        pressure_up_o;
  logic [47:0]        mean_intensity_down_o;
  logic signed [31:0] flux_down_o;
  logic [47:0]        pressure_down_o;
  logic [8:0]         levels_touched_o;

  int fail_count;
  int due_count;
  int burst_left = 0;
  int active_levels = 255;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  slab_radiation_moment_accumulator DUT (.*);
  slab_moment_checker moments_chk (.*);

  task automatic issue_item(input srma_pkg::op_e op, input int hb, input int ha,
                            input int dc, input int lvl);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    op_i               <= op;
    height_before_i    <= hb[18:0];
    height_after_i     <= ha[18:0];
    direction_cosine_i <= dc[17:0];
    read_level_i       <= lvl[7:0];
    start              <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Hold off until every predicted result has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
  endtask

  task automatic write_level(input int v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v[7:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    active_levels = v;
  endtask

  initial begin
    int  sel, kind, hb, ha, dc, step, mag, lvl;
    bit  rising;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, under the reset level count
    issue_item(srma_pkg::OP_READ, 0, 0, 0, 0);
    issue_item(srma_pkg::OP_SEGMENT, 0, 65536, 65536, 0);
    issue_item(srma_pkg::OP_SEGMENT, 65536, 0, -65536, 0);
    issue_item(srma_pkg::OP_READ, 0, 0, 0, 0);
    issue_item(srma_pkg::OP_READ, 0, 0, 0, 255);
    issue_item(srma_pkg::OP_SEGMENT, 100, 200, 1000, 0);
    issue_item(srma_pkg::OP_SEGMENT, 0, 65536, 0, 0);
    issue_item(srma_pkg::OP_SEGMENT, 262143, -262144, -131072, 0);
    issue_item(srma_pkg::OP_SEGMENT, -262144, 262143, 131071, 0);
    issue_item(srma_pkg::OP_SEGMENT, 1000, 3000, 1, 0);
    issue_item(srma_pkg::OP_SEGMENT, 3000, 1000, -1, 0);
    issue_item(srma_pkg::OP_SEGMENT, 40000, 10000, 5000, 0);
    issue_item(srma_pkg::OP_SEGMENT, -100, -5000, -3000, 0);
    issue_item(srma_pkg::OP_SEGMENT, 65536, 65536, 200, 0);
    issue_item(srma_pkg::OP_READ, 0, 0, 0, 128);
    issue_item(srma_pkg::OP_READ, 0, 0, 0, 3);
    issue_item(srma_pkg::OP_NONE, -1, -1, -1, 255);
    issue_item(srma_pkg::OP_CLEAR, 0, 0, 0, 0);
    issue_item(srma_pkg::OP_READ, 0, 0, 0, 0);
    issue_item(srma_pkg::OP_READ, 0, 0, 0, 255);

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0:       write_level(1);
        1:       write_level(255);
        3:       write_level($urandom_range(2, 8));
        default: write_level($urandom_range(2, 254));
      endcase
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(0, 149) == 0) settle();
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
          kind   = $urandom_range(0, 99);
          rising = $urandom_range(0, 1);
          mag    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16)
                                               : $urandom_range(1, 65536);
          if (kind < 65) begin
            // short hop of a few levels inside the slab
            hb   = $urandom_range(0, 65536);
            step = ($urandom_range(0, 4) * 65536) / active_levels
                   + $urandom_range(0, 65536 / active_levels);
            if (step > 100000) step = 100000;
            ha = rising ? hb + step : hb - step;
          end else if (kind < 80) begin
            // cross the floor or leave through the top
            if (rising) begin
              hb = -$urandom_range(0, 3000);
              ha = $urandom_range(0, 70000);
            end else begin
              hb = $urandom_range(0, 70000);
              ha = -$urandom_range(0, 3000);
            end
          end else begin
            hb = $urandom;
            ha = $urandom;
          end
          dc = rising ? mag : -mag;
          if (kind >= 80 && kind < 88) dc = $urandom_range(0, 1) ? 0 : -dc;
          else if (kind >= 88) dc = $urandom;
          issue_item(srma_pkg::OP_SEGMENT, hb, ha, dc, $urandom);
        end else if (sel < 93) begin
          lvl = ($urandom_range(0, 3) != 0) ? $urandom_range(0, active_levels)
                                            : $urandom_range(0, 255);
          issue_item(srma_pkg::OP_READ, $urandom, $urandom, $urandom, lvl);
        end else if (sel < 96) begin
          issue_item(srma_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
        end else begin
          issue_item(srma_pkg::OP_NONE, $urandom, $urandom, $urandom, $urandom);
        end
      end
    end

    settle();
    repeat (600) @(posedge clk_i);
    if (fail_count == 0 && due_count == 0) begin
      $display("[slab_radiation_moment_accumulator] OK");
    end else begin
      $display("[slab_radiation_moment_accumulator] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[slab_radiation_moment_accumulator] ERROR");
    $finish;
  end

endmodule

// File: filelist.f
sv/srma_pkg.sv
sv/srma_recip.sv
sv/slab_radiation_moment_accumulator.sv
bench/slab_moment_checker.sv
bench/slab_radiation_moment_accumulator_tb.sv
